[rtl/pgpsig_pkg.sv]
// Shared types, codes and constants of the OpenPGP signature packet parser.
package pgpsig_pkg;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 4;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned INDEX_W = 13;
    localparam int unsigned ERR_W   = 4;
    localparam int unsigned AREA_W  = 17;
    localparam int unsigned SUB_W   = 14;

    // Packet constants
    localparam logic [7:0]       VERSION_4        = 8'd4;
    localparam logic [3:0]       TAG_SIGNATURE    = 4'd2;
    localparam logic [7:0]       LEN_TWO_BYTE     = 8'd192;
    localparam logic [7:0]       LEN_RESERVED     = 8'd255;
    localparam logic [7:0]       SUBTYPE_ISSUER   = 8'd16;
    localparam logic [7:0]       SUBTYPE_FPR      = 8'd33;
    localparam logic [SUB_W-1:0] ISSUER_LEN       = 14'd9;
    localparam logic [SUB_W-1:0] FPR_MIN_LEN      = 14'd22;
    localparam logic [SUB_W-1:0] ISSUER_LAST_OFF  = 14'd8;
    localparam logic [SUB_W-1:0] FPR_FIRST_OFF    = 14'd2;
    localparam logic [SUB_W-1:0] FPR_LAST_OFF     = 14'd21;

    // Parser phase
    typedef enum logic [4:0] {
        P_TAG, P_LEN, P_VER, P_STYPE, P_PALG, P_HALG, P_HLEN_HI, P_HLEN_LO,
        P_SUB_LEN1, P_SUB_LEN2, P_SUB_BODY, P_ULEN_HI, P_ULEN_LO, P_HL0, P_HL1,
        P_SLEN_HI, P_SLEN_LO, P_SIG, P_DONE, P_ERR
    } phase_t;

    // Record kinds
    typedef enum logic [KIND_W-1:0] {
        K_SIGTYPE      = 4'd0,
        K_PUBALGO      = 4'd1,
        K_HASHALGO     = 4'd2,
        K_HASHED_LEN   = 4'd3,
        K_ISSUER       = 4'd4,
        K_FPR_WORD     = 4'd5,
        K_UNHASHED_LEN = 4'd6,
        K_HASH_LEFT    = 4'd7,
        K_SIG_BITS     = 4'd8,
        K_SIG_BYTE     = 4'd9,
        K_ERROR        = 4'd10
    } rec_kind_t;

    // Error codes
    typedef enum logic [ERR_W-1:0] {
        E_NONE          = 4'd0,
        E_NO_MARKER     = 4'd1,
        E_NEW_FORMAT    = 4'd2,
        E_INDET_LEN     = 4'd3,
        E_NOT_SIGNATURE = 4'd4,
        E_BAD_VERSION   = 4'd5,
        E_SUBLEN_255    = 4'd6,
        E_ISSUER_LEN    = 4'd7,
        E_SHORT_FPR     = 4'd8,
        E_AREA_OVERRUN  = 4'd9,
        E_TRUNCATED     = 4'd10
    } err_code_t;

    // Area selector kept in field_byte_count while walking subpackets
    localparam logic [2:0] AREA_HASHED   = 3'd0;
    localparam logic [2:0] AREA_UNHASHED = 3'd1;

    // Parser state
    typedef struct packed {
        phase_t               phase;
        logic [2:0]           field_byte_count;
        logic [AREA_W-1:0]    area_remaining;
        // one bit wider than SUB_W: a two-byte length (up to 16319) is held whole until
        // the type byte has been checked
        logic [SUB_W:0]       subpacket_remaining;
        logic [7:0]           subpacket_type;
        logic [SUB_W-1:0]     subpacket_offset;
        logic [VALUE_W-1:0]   value_accumulator;
        logic [SUB_W-1:0]     signature_bytes_left;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:                P_TAG,
        field_byte_count:     '0,
        area_remaining:       '0,
        subpacket_remaining:  '0,
        subpacket_type:       '0,
        subpacket_offset:     '0,
        value_accumulator:    '0,
        signature_bytes_left: '0
    };

    // One result record
    typedef struct packed {
        rec_kind_t            kind;
        logic [VALUE_W-1:0]   value;
        logic [INDEX_W-1:0]   index;
        err_code_t            err;
        logic                 fin;
    } record_t;

endpackage

[rtl/pgpsig_in_if.sv]
// Byte request channel into the parser.
interface pgpsig_in_if
    import pgpsig_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_packet;

    modport source (output valid, output data_byte, output end_of_packet, input ready);
    modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

[rtl/pgpsig_out_if.sv]
// Record request channel out of the parser.
interface pgpsig_out_if
    import pgpsig_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  record_kind;
    logic [VALUE_W-1:0] record_value;
    logic [INDEX_W-1:0] record_index;
    logic [ERR_W-1:0]   error_code;
    logic               final_res;

    modport source (output valid, output record_kind, output record_value,
                    output record_index, output error_code, output final_res,
                    input ready);
    modport sink   (input valid, input record_kind, input record_value,
                    input record_index, input error_code, input final_res,
                    output ready);
endinterface

[rtl/pgpsig_step.sv]
// Per-byte next-state and record logic of the signature packet parser.
module pgpsig_step
    import pgpsig_pkg::*;
(
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              end_of_packet,
    input  state_t            st,
    output state_t            st_next,
    output logic              rec_valid,
    output record_t           rec
);

    function automatic record_t err_rec(input err_code_t code);
        record_t r;
        r.kind  = K_ERROR;
        r.value = '0;
        r.index = '0;
        r.err   = code;
        r.fin   = 1'b1;
        return r;
    endfunction

    function automatic record_t data_rec(input rec_kind_t kind,
                                         input logic [VALUE_W-1:0] value,
                                         input logic [INDEX_W-1:0] index,
                                         input logic fin);
        record_t r;
        r.kind  = kind;
        r.value = value;
        r.index = index;
        r.err   = E_NONE;
        r.fin   = fin;
        return r;
    endfunction

    // Where to go once a subpacket (or an area) is used up
    function automatic phase_t after_sub(input logic [AREA_W-1:0] area,
                                         input logic [2:0] fbc);
        phase_t p;
        if (area != '0)
            p = P_SUB_LEN1;
        else if (fbc == AREA_HASHED)
            p = P_ULEN_HI;
        else
            p = P_HL0;
        return p;
    endfunction

    always_comb
    begin
        logic [AREA_W-1:0]  plen;
        logic [AREA_W-1:0]  need;
        logic               do_start;
        logic [1:0]         hdr;
        logic [15:0]        v16;
        logic [SUB_W-1:0]   off;
        logic [SUB_W-1:0]   k;
        logic [SUB_W-1:0]   rem_dec;
        logic [SUB_W-1:0]   sbl;
        logic [16:0]        bits_round;
        logic [VALUE_W-1:0] acc_new;
        logic               body_fail;

        st_next    = st;
        rec_valid  = 1'b0;
        rec        = data_rec(K_SIGTYPE, '0, '0, 1'b0);
        plen       = '0;
        need       = '0;
        do_start   = 1'b0;
        hdr        = 2'd0;
        v16        = {st.value_accumulator[7:0], data_byte};
        off        = st.subpacket_offset;
        k          = st.subpacket_offset - FPR_FIRST_OFF;
        rem_dec    = st.subpacket_remaining[SUB_W-1:0] - 14'd1;
        bits_round = {1'b0, v16} + 17'd7;
        sbl        = bits_round[16:3];
        acc_new    = st.value_accumulator;
        body_fail  = 1'b0;

        // Byte dispatch by phase
        case (st.phase)
            P_TAG:
            begin
                if (!data_byte[7])
                begin
                    rec_valid = 1'b1; rec = err_rec(E_NO_MARKER); st_next.phase = P_ERR;
                end
                else if (data_byte[6])
                begin
                    rec_valid = 1'b1; rec = err_rec(E_NEW_FORMAT); st_next.phase = P_ERR;
                end
                else if (data_byte[1:0] == 2'd3)
                begin
                    rec_valid = 1'b1; rec = err_rec(E_INDET_LEN); st_next.phase = P_ERR;
                end
                else if (data_byte[5:2] != TAG_SIGNATURE)
                begin
                    rec_valid = 1'b1; rec = err_rec(E_NOT_SIGNATURE); st_next.phase = P_ERR;
                end
                else
                begin
                    case (data_byte[1:0])
                        2'd0:    st_next.field_byte_count = 3'd1;
                        2'd1:    st_next.field_byte_count = 3'd2;
                        default: st_next.field_byte_count = 3'd4;
                    endcase
                    st_next.phase = P_LEN;
                end
            end
            P_LEN:
            begin
                st_next.field_byte_count = st.field_byte_count - 3'd1;
                if (st_next.field_byte_count == 3'd0)
                    st_next.phase = P_VER;
            end
            P_VER:
            begin
                if (data_byte != VERSION_4)
                begin
                    rec_valid = 1'b1; rec = err_rec(E_BAD_VERSION); st_next.phase = P_ERR;
                end
                else
                    st_next.phase = P_STYPE;
            end
            P_STYPE:
            begin
                rec_valid = 1'b1;
                rec = data_rec(K_SIGTYPE, {56'd0, data_byte}, '0, 1'b0);
                st_next.phase = P_PALG;
            end
            P_PALG:
            begin
                rec_valid = 1'b1;
                rec = data_rec(K_PUBALGO, {56'd0, data_byte}, '0, 1'b0);
                st_next.phase = P_HALG;
            end
            P_HALG:
            begin
                rec_valid = 1'b1;
                rec = data_rec(K_HASHALGO, {56'd0, data_byte}, '0, 1'b0);
                st_next.phase = P_HLEN_HI;
            end
            // High bytes of two-byte fields
            P_HLEN_HI:
            begin
                st_next.value_accumulator = {56'd0, data_byte};
                st_next.phase = P_HLEN_LO;
            end
            P_ULEN_HI:
            begin
                st_next.value_accumulator = {56'd0, data_byte};
                st_next.phase = P_ULEN_LO;
            end
            P_HL0:
            begin
                st_next.value_accumulator = {56'd0, data_byte};
                st_next.phase = P_HL1;
            end
            P_SLEN_HI:
            begin
                st_next.value_accumulator = {56'd0, data_byte};
                st_next.phase = P_SLEN_LO;
            end
            // Area lengths
            P_HLEN_LO, P_ULEN_LO:
            begin
                rec_valid = 1'b1;
                rec = data_rec((st.phase == P_HLEN_LO) ? K_HASHED_LEN : K_UNHASHED_LEN,
                               {48'd0, v16}, '0, 1'b0);
                st_next.field_byte_count = (st.phase == P_HLEN_LO) ? AREA_HASHED
                                                                   : AREA_UNHASHED;
                st_next.area_remaining = {1'b0, v16};
                st_next.phase = after_sub({1'b0, v16}, st_next.field_byte_count);
            end
            // Subpacket length, first byte
            P_SUB_LEN1:
            begin
                if (data_byte < LEN_TWO_BYTE)
                begin
                    do_start = 1'b1;
                    plen     = {9'd0, data_byte};
                    hdr      = 2'd1;
                end
                else if (data_byte < LEN_RESERVED)
                begin
                    st_next.value_accumulator = {56'd0, data_byte - LEN_TWO_BYTE};
                    st_next.phase = P_SUB_LEN2;
                end
                else
                begin
                    rec_valid = 1'b1; rec = err_rec(E_SUBLEN_255); st_next.phase = P_ERR;
                end
            end
            // Subpacket length, second byte
            P_SUB_LEN2:
            begin
                do_start = 1'b1;
                plen     = {3'd0, st.value_accumulator[5:0], 8'd0}
                           + {9'd0, data_byte} + {9'd0, LEN_TWO_BYTE};
                hdr      = 2'd2;
            end
            // Subpacket body
            P_SUB_BODY:
            begin
                if (off == '0)
                begin
                    st_next.subpacket_type = data_byte;
                    if (data_byte == SUBTYPE_ISSUER
                        && st.subpacket_remaining != {1'b0, ISSUER_LEN})
                    begin
                        body_fail = 1'b1;
                        rec_valid = 1'b1; rec = err_rec(E_ISSUER_LEN); st_next.phase = P_ERR;
                    end
                    else if (data_byte == SUBTYPE_FPR
                             && st.subpacket_remaining < {1'b0, FPR_MIN_LEN})
                    begin
                        body_fail = 1'b1;
                        rec_valid = 1'b1; rec = err_rec(E_SHORT_FPR); st_next.phase = P_ERR;
                    end
                end
                else if (st.subpacket_type == SUBTYPE_ISSUER && off <= ISSUER_LAST_OFF)
                begin
                    acc_new = (off == 14'd1) ? {56'd0, data_byte}
                                             : {st.value_accumulator[55:0], data_byte};
                    st_next.value_accumulator = acc_new;
                    if (off == ISSUER_LAST_OFF)
                    begin
                        rec_valid = 1'b1;
                        rec = data_rec(K_ISSUER, acc_new, '0, 1'b0);
                    end
                end
                else if (st.subpacket_type == SUBTYPE_FPR && off >= FPR_FIRST_OFF
                         && off <= FPR_LAST_OFF)
                begin
                    acc_new = (k[1:0] == 2'd0) ? {56'd0, data_byte}
                              : {32'd0, st.value_accumulator[23:0], data_byte};
                    st_next.value_accumulator = acc_new;
                    if (k[1:0] == 2'd3)
                    begin
                        rec_valid = 1'b1;
                        rec = data_rec(K_FPR_WORD, acc_new,
                                       {{(INDEX_W-3){1'b0}}, k[4:2]}, 1'b0);
                    end
                end
                if (!body_fail)
                begin
                    st_next.subpacket_offset    = off + 14'd1;
                    st_next.subpacket_remaining = {1'b0, rem_dec};
                    if (rem_dec == '0)
                        st_next.phase = after_sub(st.area_remaining, st.field_byte_count);
                end
            end
            P_HL1:
            begin
                rec_valid = 1'b1;
                rec = data_rec(K_HASH_LEFT, {48'd0, v16}, '0, 1'b0);
                st_next.phase = P_SLEN_HI;
            end
            // Signature bit count
            P_SLEN_LO:
            begin
                st_next.signature_bytes_left = sbl;
                st_next.subpacket_offset     = '0;
                rec_valid = 1'b1;
                rec = data_rec(K_SIG_BITS, {48'd0, v16}, '0, sbl == '0);
                st_next.phase = (sbl == '0) ? P_DONE : P_SIG;
            end
            // Signature bytes
            P_SIG:
            begin
                st_next.signature_bytes_left = st.signature_bytes_left - 14'd1;
                rec_valid = 1'b1;
                rec = data_rec(K_SIG_BYTE, {56'd0, data_byte},
                               st.subpacket_offset[INDEX_W-1:0],
                               st_next.signature_bytes_left == '0);
                st_next.subpacket_offset = st.subpacket_offset + 14'd1;
                if (st_next.signature_bytes_left == '0)
                    st_next.phase = P_DONE;
            end
            default:
            begin
            end
        endcase

        // Subpacket header done: bound check against the area, then enter body (or move on if it is empty)
        if (do_start)
        begin
            need = plen + {15'd0, hdr};
            if (need > st.area_remaining)
            begin
                rec_valid = 1'b1; rec = err_rec(E_AREA_OVERRUN); st_next.phase = P_ERR;
            end
            else
            begin
                st_next.area_remaining      = st.area_remaining - need;
                st_next.subpacket_remaining = plen[SUB_W:0];
                st_next.subpacket_offset    = '0;
                st_next.subpacket_type      = '0;
                if (plen == '0)
                    st_next.phase = after_sub(st_next.area_remaining, st.field_byte_count);
                else
                    st_next.phase = P_SUB_BODY;
            end
        end

        // End of packet: flag truncation, then back to the tag byte
        if (end_of_packet)
        begin
            if (st_next.phase != P_DONE && st_next.phase != P_ERR)
            begin
                rec_valid = 1'b1;
                rec = err_rec(E_TRUNCATED);
            end
            st_next = STATE_RESET;
        end
    end

endmodule

[rtl/pgp_signature_packet_parser.sv]
// Records are registered: a record appears on the output in the cycle after its byte is accepted.
// Throughput: one byte per cycle; a byte is taken whenever the output register
//   is empty or its record is taken in the same cycle.
// Reset (rst_n low, asynchronous): parser returns to expecting a tag byte and
//   any pending record is dropped.
// Top level of the OpenPGP v4 signature packet parser.
module pgp_signature_packet_parser
    import pgpsig_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    pgpsig_in_if.sink    in_ch,
    pgpsig_out_if.source out_ch
);

    state_t  st_reg;
    state_t  st_next;
    record_t rec_reg;
    record_t rec_next;
    logic    rec_valid;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    in_fire;

    // Byte decode
    pgpsig_step u_step (
        .data_byte     (in_ch.data_byte),
        .end_of_packet (in_ch.end_of_packet),
        .st            (st_reg),
        .st_next       (st_next),
        .rec_valid     (rec_valid),
        .rec           (rec_next)
    );

    // Input handshake
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // Output valid tracking
    always_comb
    begin
        if (in_fire)
            out_valid_next = rec_valid;
        else
            out_valid_next = out_valid_reg && !out_ch.ready;
    end

    // Parser state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
                st_reg <= st_next;
        end
    end

    // Record payload
    always_ff @(posedge clk)
    begin
        if (in_fire && rec_valid)
            rec_reg <= rec_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.record_kind  = rec_reg.kind;
    assign out_ch.record_value = rec_reg.value;
    assign out_ch.record_index = rec_reg.index;
    assign out_ch.error_code   = rec_reg.err;
    assign out_ch.final_res    = rec_reg.fin;

endmodule
